@@ design/lse_pkg.sv @@
`default_nettype none
package lse_pkg;

  localparam int unsigned PIXEL_W   = 8;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned LEN_BYTES = 4;
  localparam int unsigned HDR_BYTES = 8;
  localparam int unsigned HDR_IDX_W = 4;
  localparam int unsigned BITPOS_W  = 3;
  localparam int unsigned OUT_DATA_W = 2 * WORD_W + BYTE_W;

  localparam logic KIND_ID   = 1'b0;
  localparam logic KIND_DATA = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [WORD_W-1:0]   hidden_id;
    logic [WORD_W-1:0]   payload_length;
    logic [BYTE_W-1:0]   data_byte;
    logic                last;
  } lse_result_t;

endpackage
`default_nettype wire

@@ design/lse_core.sv @@
`default_nettype none
module lse_core
  import lse_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic        bit_i,
  input  wire logic        start_i,
  output logic             res_valid,
  output lse_result_t      res
);

  logic [BYTE_W-2:0]    gather_r, gather_nxt, gather_eff;
  logic [BITPOS_W-1:0]  pos_r, pos_nxt, pos_eff;
  logic [HDR_IDX_W-1:0] hdr_r, hdr_nxt, hdr_eff;
  logic [WORD_W-1:0]    len_r, len_nxt, len_eff;
  logic [WORD_W-1:0]    id_r, id_nxt, id_eff;
  logic [WORD_W-1:0]    cnt_r, cnt_nxt, cnt_eff, cnt_inc;
  logic                 fin_r, fin_nxt, fin_eff;
  logic [BYTE_W-1:0]    byte_w;
  logic                 has_payload;

  // a start flag restarts extraction before this pixel is used
  always_comb begin
    gather_eff = start_i ? '0 : gather_r;
    pos_eff    = start_i ? '0 : pos_r;
    hdr_eff    = start_i ? '0 : hdr_r;
    len_eff    = start_i ? '0 : len_r;
    id_eff     = start_i ? '0 : id_r;
    cnt_eff    = start_i ? '0 : cnt_r;
    fin_eff    = start_i ? 1'b0 : fin_r;
  end

  assign byte_w      = {bit_i, gather_eff};
  assign cnt_inc     = cnt_eff + WORD_W'(1);
  assign has_payload = (len_eff != '0) && !len_eff[WORD_W-1];

  always_comb begin
    gather_nxt = gather_eff;
    pos_nxt    = pos_eff;
    hdr_nxt    = hdr_eff;
    len_nxt    = len_eff;
    id_nxt     = id_eff;
    cnt_nxt    = cnt_eff;
    fin_nxt    = fin_eff;
    res_valid  = 1'b0;
    res        = '0;
    if (!fin_eff) begin
      if (pos_eff != '1) begin
        gather_nxt = gather_eff | ((BYTE_W-1)'(bit_i) << pos_eff);
        pos_nxt    = pos_eff + BITPOS_W'(1);
      end else begin
        gather_nxt = '0;
        pos_nxt    = '0;
        if (hdr_eff < HDR_IDX_W'(LEN_BYTES)) begin
          len_nxt = {len_eff[WORD_W-BYTE_W-1:0], byte_w};
          hdr_nxt = hdr_eff + HDR_IDX_W'(1);
        end else if (hdr_eff < HDR_IDX_W'(HDR_BYTES)) begin
          id_nxt  = {id_eff[WORD_W-BYTE_W-1:0], byte_w};
          hdr_nxt = hdr_eff + HDR_IDX_W'(1);
          if (hdr_eff == HDR_IDX_W'(HDR_BYTES - 1)) begin
            res_valid          = 1'b1;
            res.kind           = KIND_ID;
            res.hidden_id      = id_nxt;
            res.payload_length = len_eff;
            res.last           = !has_payload;
            fin_nxt            = !has_payload;
          end
        end else begin
          cnt_nxt       = cnt_inc;
          res_valid     = 1'b1;
          res.kind      = KIND_DATA;
          res.data_byte = byte_w;
          res.last      = (cnt_inc == len_eff);
          fin_nxt       = (cnt_inc == len_eff);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gather_r <= '0;
      pos_r    <= '0;
      hdr_r    <= '0;
      len_r    <= '0;
      id_r     <= '0;
      cnt_r    <= '0;
      fin_r    <= 1'b0;
    end else if (en) begin
      gather_r <= gather_nxt;
      pos_r    <= pos_nxt;
      hdr_r    <= hdr_nxt;
      len_r    <= len_nxt;
      id_r     <= id_nxt;
      cnt_r    <= cnt_nxt;
      fin_r    <= fin_nxt;
    end
  end

endmodule
`default_nettype wire

@@ design/lsb_stego_extractor.sv @@
// LSB steganography extractor. Gray pixels stream in one per transfer, with
// in_tuser marking the first pixel of an image. The low bit of each group of
// eight pixels builds a byte (pixel i of the group gives bit i); the first
// four bytes are a big-endian payload length, the next four a 32-bit hidden
// identifier. After the 64th pixel one identifier transfer (out_tuser = 0)
// carries identifier and length; then one payload byte (out_tuser = 1) comes
// per eight pixels until the length is reached, the final one with out_tlast.
// A zero length or one with bit 31 set gives no payload, and the identifier
// transfer carries out_tlast. Pixels after that are dropped until the next
// image start. One pixel is taken every cycle while no result waits on out_tready;
// the pixel that completes a result passes through the input register, and
// the result through the result register, before it is offered.
`default_nettype none
module lsb_stego_extractor
  import lse_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [PIXEL_W-1:0]    in_tdata,   // [7:0] pixel
  input  wire logic                  in_tuser,   // [0] image_start
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // [31:0] hidden_id,
                                                 // [63:32] payload_length,
                                                 // [71:64] data_byte
  output logic                       out_tuser,  // [0] result_kind
  output logic                       out_tlast   // last
);

  logic        in_valid_r;
  logic        bit_r;
  logic        start_r;
  logic        proc_en;
  logic        res_valid;
  lse_result_t res;
  lse_result_t out_r;
  logic        out_valid_r;

  // input register advances when the result slot can take whatever it makes
  assign proc_en   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || proc_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      bit_r   <= in_tdata[0];
      start_r <= in_tuser;
    end
  end

  lse_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (proc_en),
    .bit_i     (bit_r),
    .start_i   (start_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc_en) begin
      out_valid_r <= res_valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_en && res_valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r.data_byte, out_r.payload_length, out_r.hidden_id};
  assign out_tuser  = out_r.kind;
  assign out_tlast  = out_r.last;

endmodule
`default_nettype wire

@@ tb/lsb_stego_extractor_tb.sv @@
`timescale 1ns / 1ps
module lsb_stego_extractor_tb;
  import lse_pkg::*;

  localparam int IDLE_LIMIT = 1000;
  localparam int LONG_HOLD  = 250;
  localparam int CALM_LEFT  = 150;

  typedef struct packed {
    logic [PIXEL_W-1:0] px;
    logic               st;
    logic               drain;
  } pixel_item_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [PIXEL_W-1:0]    in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;

  pixel_item_t pix_q[$];
  lse_result_t expected_q[$];

  // extractor state mirrored on the testbench side
  logic [6:0]        gather_bits = '0;
  logic [2:0]        bit_pos = '0;
  logic [3:0]        hdr_idx = '0;
  logic [WORD_W-1:0] len_word = '0;
  logic [WORD_W-1:0] id_word = '0;
  logic [WORD_W-1:0] bytes_out = '0;
  logic              image_done = 1'b0;

  int   errors = 0;
  int   idle_cycles = 0;
  int   rx_total = 0;
  int   rx_gap = 0;
  int   rx_hold = 0;
  int   long_holds = 0;
  int   tx_gap = 0;
  logic in_taken = 1'b0;
  logic rx_cue = 1'b0;

  lsb_stego_extractor i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic extract_pixel(input logic [PIXEL_W-1:0] px, input logic st,
                                         output lse_result_t res);
    logic [BYTE_W-1:0] byte_val;
    res = '0;
    if (st) begin
      gather_bits = '0;
      bit_pos     = '0;
      hdr_idx     = '0;
      len_word    = '0;
      id_word     = '0;
      bytes_out   = '0;
      image_done  = 1'b0;
    end
    if (image_done) return 1'b0;
    if (bit_pos != 3'd7) begin
      gather_bits[bit_pos] = px[0];
      bit_pos = bit_pos + 3'd1;
      return 1'b0;
    end
    byte_val    = {px[0], gather_bits};
    gather_bits = '0;
    bit_pos     = '0;
    if (hdr_idx < LEN_BYTES) begin
      len_word = {len_word[WORD_W-BYTE_W-1:0], byte_val};
      hdr_idx  = hdr_idx + 4'd1;
      return 1'b0;
    end
    if (hdr_idx < HDR_BYTES) begin
      id_word = {id_word[WORD_W-BYTE_W-1:0], byte_val};
      hdr_idx = hdr_idx + 4'd1;
      if (hdr_idx < HDR_BYTES) return 1'b0;
      res.kind           = KIND_ID;
      res.hidden_id      = id_word;
      res.payload_length = len_word;
      // a zero length or a negative one ends the image right here
      res.last   = (len_word == '0) || len_word[WORD_W-1];
      image_done = res.last;
      return 1'b1;
    end
    bytes_out     = bytes_out + WORD_W'(1);
    res.kind      = KIND_DATA;
    res.data_byte = byte_val;
    res.last      = (bytes_out == len_word);
    image_done    = res.last;
    return 1'b1;
  endfunction

  task automatic put_px(input logic b, input logic st, input logic dr);
    pixel_item_t it;
    logic [PIXEL_W-1:0] raw;
    raw      = PIXEL_W'($urandom);
    raw[0]   = b;
    it.px    = raw;
    it.st    = st;
    it.drain = dr;
    pix_q.push_back(it);
  endtask

  task automatic put_byte(input logic [BYTE_W-1:0] b, input logic st, input logic dr);
    for (int k = 0; k < 8; k++) put_px(b[k], (k == 0) ? st : 1'b0, (k == 0) ? dr : 1'b0);
  endtask

  task automatic put_image(input logic st, input logic [WORD_W-1:0] len,
                           input logic [WORD_W-1:0] id, input int body, input int tail,
                           input logic dr);
    logic [2*WORD_W-1:0] hdr;
    hdr = {len, id};
    for (int k = 0; k < HDR_BYTES; k++)
      put_byte(hdr[2*WORD_W-1-8*k -: 8], (k == 0) ? st : 1'b0, (k == 0) ? dr : 1'b0);
    for (int k = 0; k < body; k++) put_byte(BYTE_W'($urandom), 1'b0, 1'b0);
    for (int k = 0; k < tail; k++) put_px(1'($urandom), 1'b0, 1'b0);
  endtask

  // sender: hold each pixel until taken; idle in bursts or to drain results
  always @(negedge clk) begin
    logic v;
    if (rst_n) begin
      if (in_taken) void'(pix_q.pop_front());
      v = 1'b0;
      if (in_tvalid && !in_taken) begin
        v = 1'b1;
      end else if (tx_gap > 0) begin
        tx_gap--;
      end else if (pix_q.size() > 0) begin
        if (pix_q[0].drain && expected_q.size() != 0) begin
          v = 1'b0;
        end else if (pix_q.size() >= CALM_LEFT && $urandom_range(0, 11) == 0) begin
          tx_gap = $urandom_range(1, 12) - 1;
        end else begin
          v = 1'b1;
        end
      end
      if (v) begin
        in_tdata <= pix_q[0].px;
        in_tuser <= pix_q[0].st;
      end
      in_tvalid <= v;
    end
  end

  // receiver: random stalls, plus long hold-offs right after a mid-payload byte
  always @(negedge clk) begin
    logic rdy;
    if (rst_n) begin
      rdy = 1'b1;
      if (rx_cue && long_holds < 2 && rx_total >= 15 + 30 * long_holds &&
          pix_q.size() >= CALM_LEFT) begin
        rx_hold = LONG_HOLD;
        long_holds++;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        rdy = 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        rdy = 1'b0;
      end else if (pix_q.size() >= CALM_LEFT && $urandom_range(0, 9) == 0) begin
        rx_gap = $urandom_range(1, 12) - 1;
        rdy = 1'b0;
      end
      out_tready <= rdy;
    end
  end

  always @(posedge clk) begin
    lse_result_t fresh;
    lse_result_t want;
    lse_result_t got;
    logic        cue;
    if (rst_n) begin
      in_taken <= in_tvalid && in_tready;
      cue = 1'b0;
      if (in_tvalid && in_tready) begin
        if (extract_pixel(in_tdata, in_tuser, fresh)) expected_q.push_back(fresh);
      end
      if (out_tvalid && out_tready) begin
        got.kind           = out_tuser;
        got.hidden_id      = out_tdata[WORD_W-1:0];
        got.payload_length = out_tdata[2*WORD_W-1:WORD_W];
        got.data_byte      = out_tdata[2*WORD_W+BYTE_W-1:2*WORD_W];
        got.last           = out_tlast;
        rx_total++;
        cue = (got.kind == KIND_DATA) && !got.last;
        if (expected_q.size() == 0) begin
          $error("result with nothing pending: kind %b data %h last %b",
                 got.kind, out_tdata, got.last);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (got.kind !== want.kind) begin
            $error("result_kind: expected %b, got %b", want.kind, got.kind);
            errors++;
          end
          if (got.hidden_id !== want.hidden_id) begin
            $error("hidden_id: expected %h, got %h", want.hidden_id, got.hidden_id);
            errors++;
          end
          if (got.payload_length !== want.payload_length) begin
            $error("payload_length: expected %h, got %h",
                   want.payload_length, got.payload_length);
            errors++;
          end
          if (got.data_byte !== want.data_byte) begin
            $error("data_byte: expected %h, got %h", want.data_byte, got.data_byte);
            errors++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %b, got %b", want.last, got.last);
            errors++;
          end
        end
      end
      rx_cue <= cue;
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    logic [WORD_W-1:0] len;
    int sel;
    int body;
    int n;

    // header from reset with no image start, then pixels past the end
    put_image(1'b0, 32'd2, 32'h0000_0000, 2, 5, 1'b0);
    put_image(1'b1, 32'd0, 32'h1234_5678, 0, 9, 1'b1);
    put_image(1'b1, 32'h8000_0000, 32'hFFFF_FFFF, 0, 8, 1'b0);
    put_image(1'b1, 32'hFFFF_FFFF, 32'hA5A5_5A5A, 0, 3, 1'b0);
    put_image(1'b1, 32'd1, 32'hFEDC_BA98, 0, 0, 1'b1);
    put_byte(8'hFF, 1'b0, 1'b0);
    for (int k = 0; k < 4; k++) put_px(1'b1, 1'b0, 1'b0);
    put_image(1'b1, 32'd3, 32'h0F0F_F0F0, 0, 0, 1'b0);
    put_byte(8'h00, 1'b0, 1'b0);
    put_byte(8'hA5, 1'b0, 1'b0);
    put_byte(8'h5A, 1'b0, 1'b0);
    // large positive length, cut short partway through a byte
    put_image(1'b1, 32'h7FFF_FFFF, 32'h8765_4321, 2, 3, 1'b0);
    // image start in the middle of a header
    for (int k = 0; k < 20; k++) put_px(1'($urandom), k == 0, 1'b0);
    put_image(1'b1, 32'd4, 32'h0000_0001, 4, 2, 1'b1);

    while (pix_q.size() < 1950) begin
      sel = $urandom_range(0, 9);
      if (sel < 7) begin
        len = $urandom_range(0, 16);
        if ($urandom_range(0, 9) == 0) len = $urandom;
        body = (len > 16) ? $urandom_range(0, 3) : int'(len);
        if ($urandom_range(0, 9) == 0 && body > 0) body = $urandom_range(0, body - 1);
        put_image(1'b1, len, $urandom, body, $urandom_range(0, 10),
                  $urandom_range(0, 7) == 0);
      end else if (sel < 9) begin
        n = $urandom_range(1, 40);
        for (int k = 0; k < n; k++)
          put_px(1'($urandom), $urandom_range(0, 49) == 0, 1'b0);
      end else begin
        n = $urandom_range(1, 63);
        for (int k = 0; k < n; k++) put_px(1'($urandom), k == 0, 1'b0);
      end
    end

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    while (pix_q.size() != 0 || in_tvalid) @(negedge clk);
    while (expected_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
